### hw/rtl/doc_pkg.sv
package doc_pkg;

    // fixed widths of the stream fields
    localparam int FIELD_BITS    = 32;
    localparam int IN_DATA_BITS  = 72;
    localparam int OUT_DATA_BITS = 8;

    typedef logic [1:0] order_t;

    localparam order_t ORD_LESS    = 2'd0;
    localparam order_t ORD_EQUAL   = 2'd1;
    localparam order_t ORD_GREATER = 2'd2;

    // what an item carries into the compare stage
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_SIGN,
        KIND_CMP
    } kind_t;

endpackage

### hw/rtl/direction_order_compare_top.sv
// Orders two directions given as a stream of coordinate pairs, one pair per item, with
// tlast on the final pair; the order (less, equal, greater) comes out as one item per
// tlast. One pair is taken every cycle unless m_axis_tready back-pressure stalls the input.
// A result goes from its tlast item through the input, cross-product and result
// registers; the two COORD_BITS x COORD_BITS+1 multiplies sit between the first two
// registers. Coordinates use only their low COORD_BITS bits as two's complement.
module direction_order_compare_top #(
    parameter int COORD_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] coord_first, [63:32] coord_second, [71:64] zero
    input  logic [doc_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [1:0] order, [7:2] zero
    output logic [doc_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata
);
    import doc_pkg::*;

    localparam int PROD_BITS = 2 * COORD_BITS + 1;

    typedef enum logic [1:0] {
        FR_SEEK,
        FR_CMP,
        FR_DONE
    } front_t;

    // input register
    logic                         in_valid_reg;
    logic signed [COORD_BITS-1:0] in_first_reg;
    logic signed [COORD_BITS-1:0] in_second_reg;
    logic                         in_last_reg;

    // scale state ahead of the multiplies
    front_t                       front_reg, front_next;
    logic [COORD_BITS-1:0]        scale_first_reg, scale_first_next;
    logic [COORD_BITS-1:0]        scale_second_reg, scale_second_next;

    // product register
    logic                         mul_valid_reg;
    kind_t                        mul_kind_reg, mul_kind_next;
    order_t                       mul_sign_reg, mul_sign_next;
    logic signed [PROD_BITS-1:0]  mul_pa_reg, mul_pa_next;
    logic signed [PROD_BITS-1:0]  mul_pb_reg, mul_pb_next;
    logic                         mul_last_reg;

    // verdict state and result register
    logic                         decided_reg;
    order_t                       verdict_reg;
    logic                         out_valid_reg;
    order_t                       out_order_reg;

    logic   out_free, mul_take, mul_free, in_take;
    logic   a_nz, b_nz, a_neg, b_neg;
    logic [1:0] sa_code, sb_code;
    logic [COORD_BITS-1:0] mag_a, mag_b;
    logic signed [PROD_BITS-1:0] a_ext, b_ext, sf_ext, ss_ext;
    order_t sign_order;
    logic   decided_eff;
    order_t verdict_eff;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign mul_take      = mul_valid_reg && (!mul_last_reg || out_free);
    assign mul_free      = !mul_valid_reg || mul_take;
    assign in_take       = in_valid_reg && mul_free;
    assign s_axis_tready = !in_valid_reg || in_take;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_BITS-2){1'b0}}, out_order_reg};

    // sign codes: negative 0, zero 1, positive 2, so they order like the values
    assign a_nz    = in_first_reg != '0;
    assign b_nz    = in_second_reg != '0;
    assign a_neg   = in_first_reg[COORD_BITS-1];
    assign b_neg   = in_second_reg[COORD_BITS-1];
    assign sa_code = a_neg ? 2'd0 : (a_nz ? 2'd2 : 2'd1);
    assign sb_code = b_neg ? 2'd0 : (b_nz ? 2'd2 : 2'd1);
    assign sign_order = (sa_code < sb_code) ? ORD_LESS
                      : ((sa_code > sb_code) ? ORD_GREATER : ORD_EQUAL);

    assign mag_a = a_neg ? (~in_first_reg + 1'b1) : in_first_reg;
    assign mag_b = b_neg ? (~in_second_reg + 1'b1) : in_second_reg;

    assign a_ext  = {{(COORD_BITS+1){in_first_reg[COORD_BITS-1]}}, in_first_reg};
    assign b_ext  = {{(COORD_BITS+1){in_second_reg[COORD_BITS-1]}}, in_second_reg};
    assign sf_ext = {{(COORD_BITS+1){1'b0}}, scale_first_reg};
    assign ss_ext = {{(COORD_BITS+1){1'b0}}, scale_second_reg};
    assign mul_pa_next = sf_ext * a_ext;
    assign mul_pb_next = ss_ext * b_ext;

    always_comb
    begin
        front_next        = front_reg;
        scale_first_next  = scale_first_reg;
        scale_second_next = scale_second_reg;
        mul_kind_next     = KIND_NONE;
        mul_sign_next     = sign_order;
        unique case (front_reg)
            FR_SEEK:
            begin
                if (a_nz || b_nz)
                begin
                    if (sa_code != sb_code)
                    begin
                        mul_kind_next = KIND_SIGN;
                        front_next    = FR_DONE;
                    end
                    else
                    begin
                        // cross scales: each direction is scaled by the other's magnitude
                        scale_first_next  = mag_b;
                        scale_second_next = mag_a;
                        front_next        = FR_CMP;
                    end
                end
            end
            FR_CMP:  mul_kind_next = KIND_CMP;
            FR_DONE: mul_kind_next = KIND_NONE;
            default: mul_kind_next = KIND_NONE;
        endcase
        if (in_last_reg)
        begin
            front_next        = FR_SEEK;
            scale_first_next  = '0;
            scale_second_next = '0;
        end
    end

    always_comb
    begin
        decided_eff = decided_reg;
        verdict_eff = verdict_reg;
        if (!decided_reg)
        begin
            if (mul_kind_reg == KIND_SIGN)
            begin
                decided_eff = 1'b1;
                verdict_eff = mul_sign_reg;
            end
            else if (mul_kind_reg == KIND_CMP && mul_pa_reg != mul_pb_reg)
            begin
                decided_eff = 1'b1;
                verdict_eff = (mul_pa_reg < mul_pb_reg) ? ORD_LESS : ORD_GREATER;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            front_reg        <= FR_SEEK;
            scale_first_reg  <= '0;
            scale_second_reg <= '0;
            mul_valid_reg    <= 1'b0;
            decided_reg      <= 1'b0;
            verdict_reg      <= ORD_EQUAL;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (in_take)
            begin
                front_reg        <= front_next;
                scale_first_reg  <= scale_first_next;
                scale_second_reg <= scale_second_next;
            end
            if (mul_free)
            begin
                mul_valid_reg <= in_take;
            end
            if (mul_take)
            begin
                if (mul_last_reg)
                begin
                    decided_reg <= 1'b0;
                    verdict_reg <= ORD_EQUAL;
                end
                else
                begin
                    decided_reg <= decided_eff;
                    verdict_reg <= verdict_eff;
                end
            end
            if (out_free)
            begin
                out_valid_reg <= mul_take && mul_last_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_first_reg  <= s_axis_tdata[COORD_BITS-1:0];
            in_second_reg <= s_axis_tdata[FIELD_BITS+COORD_BITS-1:FIELD_BITS];
            in_last_reg   <= s_axis_tlast;
        end
        if (in_take)
        begin
            mul_kind_reg <= mul_kind_next;
            mul_sign_reg <= mul_sign_next;
            mul_pa_reg   <= mul_pa_next;
            mul_pb_reg   <= mul_pb_next;
            mul_last_reg <= in_last_reg;
        end
        if (out_free && mul_take && mul_last_reg)
        begin
            out_order_reg <= verdict_eff;
        end
    end

    a_order_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'b11)
        else $error("result order code out of range");

    a_decided_not_equal: assert property (@(posedge clk) disable iff (!rst_n)
        decided_reg |-> verdict_reg != ORD_EQUAL)
        else $error("decided verdict is equal");

    a_scales_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        front_reg == FR_CMP |-> (scale_first_reg != '0 && scale_second_reg != '0))
        else $error("compare phase with a zero scale");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_take && mul_last_reg) |=> m_axis_tvalid)
        else $error("final item produced no result");

endmodule

### test/direction_order_compare_top_tb.sv
module direction_order_compare_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import doc_pkg::*;

    localparam int COORD_BITS   = 32;
    localparam int IDLE_PERCENT = 19;
    localparam int HOLDOFF_AT   = 600;
    localparam int HOLDOFF_LEN  = 300;
    localparam int QUIET_FROM   = 1000;
    localparam int QUIET_TO     = 1300;
    localparam int DRAIN_AT     = 1400;
    localparam int RANDOM_PAIRS = 1800;

    typedef enum logic [1:0] {
        DIR_SEEK,
        DIR_SCALED,
        DIR_DECIDED
    } dir_phase_t;

    typedef struct {
        logic [31:0] first;
        logic [31:0] second;
        logic        last;
        logic        drain_first;
    } coord_pair_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;
    logic                     s_axis_tlast = 1'b0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;

    coord_pair_t pending_pairs[$];
    order_t      expected_orders[$];

    // predictor state
    dir_phase_t dir_phase = DIR_SEEK;
    longint     scale_first = 0;
    longint     scale_second = 0;
    order_t     dir_verdict = ORD_EQUAL;

    logic in_fire = 1'b0;
    logic mark_drain = 1'b0;
    int   pairs_taken = 0;
    int   pairs_queued = 0;
    int   runs_queued = 0;
    int   orders_checked = 0;
    int   verdict_seen[3] = '{0, 0, 0};
    int   errors = 0;
    int   holdoff_left = 0;
    logic holdoff_done = 1'b0;

    direction_order_compare_top #(
        .COORD_BITS(COORD_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic int sign_of(input longint x);
        return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
    endfunction

    function automatic order_t order_of(input longint a, input longint b);
        if (a < b)
            return ORD_LESS;
        if (a > b)
            return ORD_GREATER;
        return ORD_EQUAL;
    endfunction

    task automatic predict_pair(input logic signed [31:0] a_raw, input logic signed [31:0] b_raw,
                                input logic last);
        longint a;
        longint b;
        order_t c;
        a = a_raw;
        b = b_raw;
        case (dir_phase)
            DIR_SEEK:
                if (a != 0 || b != 0)
                begin
                    if (sign_of(a) != sign_of(b))
                    begin
                        dir_verdict = order_of(sign_of(a), sign_of(b));
                        dir_phase = DIR_DECIDED;
                    end
                    else
                    begin
                        // cross scales: each direction is scaled by the other's magnitude
                        scale_first = (b < 0) ? -b : b;
                        scale_second = (a < 0) ? -a : a;
                        dir_phase = DIR_SCALED;
                    end
                end
            DIR_SCALED:
            begin
                c = order_of(scale_first * a, scale_second * b);
                if (c != ORD_EQUAL)
                begin
                    dir_verdict = c;
                    dir_phase = DIR_DECIDED;
                end
            end
            default: ;
        endcase
        if (last)
        begin
            expected_orders.push_back(dir_verdict);
            dir_phase = DIR_SEEK;
            scale_first = 0;
            scale_second = 0;
            dir_verdict = ORD_EQUAL;
        end
    endtask

    task automatic push_pair(input logic [31:0] a, input logic [31:0] b, input logic last);
        coord_pair_t p;
        p.first = a;
        p.second = b;
        p.last = last;
        p.drain_first = mark_drain;
        mark_drain = 1'b0;
        pending_pairs.push_back(p);
        pairs_queued++;
        if (last)
            runs_queued++;
    endtask

    function automatic logic [31:0] pick_coord();
        int v;
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1, 2: return $urandom;
            3:
            begin
                v = $urandom_range(0, 200);
                v = v - 100;
                return v;
            end
            4:
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'hffff_ffff;
                    default: return 32'd1;
                endcase
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic logic quiet_stretch();
        return pairs_taken >= QUIET_FROM && pairs_taken < QUIET_TO;
    endfunction

    // sender
    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || in_fire)
        begin
            if (pending_pairs.size() != 0
                && !(pending_pairs[0].drain_first && expected_orders.size() != 0)
                && (quiet_stretch() || $urandom_range(0, 99) >= IDLE_PERCENT))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {8'h00, pending_pairs[0].second, pending_pairs[0].first};
                s_axis_tlast <= pending_pairs[0].last;
                void'(pending_pairs.pop_front());
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver, with one long hold-off so the pipeline backs up into the input
    always @(negedge clk)
    begin
        if (holdoff_left > 0)
        begin
            holdoff_left <= holdoff_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!holdoff_done && pairs_taken >= HOLDOFF_AT)
        begin
            holdoff_left <= HOLDOFF_LEN;
            holdoff_done <= 1'b1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= quiet_stretch() || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // monitor
    always @(posedge clk)
    begin
        order_t want;
        order_t got;
        in_fire <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            predict_pair(s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tlast);
            pairs_taken++;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[1:0];
            if (expected_orders.size() == 0)
            begin
                $error("unexpected order item, actual %0d", got);
                errors++;
            end
            else
            begin
                want = expected_orders.pop_front();
                if (got != want)
                begin
                    $error("order mismatch: expected %0d, actual %0d", want, got);
                    errors++;
                end
                orders_checked++;
                if (got <= ORD_GREATER)
                    verdict_seen[got]++;
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d orders outstanding", expected_orders.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int kind;
        int lead;
        int len;
        int n;
        int m;
        int base;
        int perturb_at;
        int swap;
        int neg;
        int a;
        int b;
        logic drain_done;
        int guard;

        drain_done = 1'b0;

        // directed: all zero, one and several pairs
        push_pair(32'd0, 32'd0, 1'b1);
        push_pair(32'd0, 32'd0, 1'b0);
        push_pair(32'd0, 32'd0, 1'b1);
        // signs differ at the first nonzero index
        push_pair(32'd5, -32'sd3, 1'b1);
        push_pair(-32'sd1, 32'd2, 1'b1);
        push_pair(32'd0, 32'd7, 1'b1);
        push_pair(-32'sd8, 32'd0, 1'b1);
        // same sign, decided by the cross products
        push_pair(32'd2, 32'd4, 1'b0);
        push_pair(32'd1, 32'd3, 1'b1);
        // extremes through the multipliers
        push_pair(32'h8000_0000, 32'h8000_0000, 1'b0);
        push_pair(32'h7fff_ffff, 32'h8000_0000, 1'b1);
        push_pair(32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        push_pair(32'h8000_0000, 32'h7fff_ffff, 1'b1);
        // later pairs ignored once decided
        push_pair(32'd1, -32'sd1, 1'b0);
        push_pair(-32'sd5, 32'd9, 1'b1);
        // leading zeros, equal directions
        push_pair(32'd0, 32'd0, 1'b0);
        push_pair(32'd3, 32'd3, 1'b0);
        push_pair(32'd3, 32'd3, 1'b1);
        // negative leading pair, equal for a while, then decided
        push_pair(32'd0, 32'd0, 1'b0);
        push_pair(-32'sd2, -32'sd6, 1'b0);
        push_pair(32'd1, 32'd3, 1'b0);
        push_pair(32'd9, 32'd0, 1'b1);

        while (pairs_queued < RANDOM_PAIRS)
        begin
            kind = $urandom_range(0, 9);
            lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
            n = lead + len;
            m = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2000000) : $urandom_range(1, 50);
            swap = $urandom_range(0, 1);
            neg = $urandom_range(0, 1);
            perturb_at = (len > 1 && $urandom_range(0, 1)) ? $urandom_range(1, len - 1) : -1;
            if (!drain_done && pairs_queued >= DRAIN_AT)
            begin
                mark_drain = 1'b1;
                drain_done = 1'b1;
            end
            for (int i = 0; i < n; i++)
            begin
                if (i < lead)
                    push_pair(32'd0, 32'd0, i == n - 1);
                else if (kind <= 5)
                begin
                    // proportional directions stay equal until an optional perturbation
                    base = $urandom_range(0, 2000);
                    base = base - 1000;
                    if (i == lead && base == 0)
                        base = 1;
                    a = base;
                    b = base * m;
                    if (i - lead == perturb_at)
                        b = b + ($urandom_range(0, 1) ? 1 : -1);
                    if (swap)
                        push_pair(b, a, i == n - 1);
                    else
                        push_pair(a, b, i == n - 1);
                end
                else if (kind <= 7 && i == lead)
                begin
                    a = $urandom_range(1, 32'h7fff_ffff);
                    b = $urandom_range(1, 32'h7fff_ffff);
                    if (neg)
                        push_pair(-a, -b, i == n - 1);
                    else
                        push_pair(a, b, i == n - 1);
                end
                else
                    push_pair(pick_coord(), pick_coord(), i == n - 1);
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_pairs.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        guard = 0;
        while (expected_orders.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        if (expected_orders.size() != 0)
        begin
            $error("%0d expected orders never arrived", expected_orders.size());
            errors++;
        end
        repeat (10) @(posedge clk);

        $display("%0d coordinate pairs in %0d direction pairs sent, %0d orders checked",
                 pairs_taken, runs_queued, orders_checked);
        $display("verdicts seen: less %0d, equal %0d, greater %0d; %0d errors",
                 verdict_seen[0], verdict_seen[1], verdict_seen[2], errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
